### rtl/pidwc_pkg.sv
`timescale 1ns / 1ps

package pidwc_pkg;

    // fixed field widths
    localparam int IN_W       = 32;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 32;
    localparam int LIMIT_W    = 31;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // default datapath width of error, integral and derivative
    localparam int VALUE_WIDTH_DEF = 32;

    // running sum of the three terms, and the wider width used to clamp a term
    localparam int SUM_W   = 64;
    localparam int CLAMP_W = SUM_W + 2;
    localparam logic signed [CLAMP_W-1:0] TERM_LIM = CLAMP_W'(64'sh2000_0000_0000_0000);

    // multiplier operand chunk
    localparam int CHUNK_W = 16;
    localparam int FRAC_W  = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P           = 3'd0,
        REG_GAIN_I           = 3'd1,
        REG_GAIN_D           = 3'd2,
        REG_ERROR_STEP_LIMIT = 3'd3,
        REG_INTEGRAL_LIMIT   = 3'd4
    } cfg_reg_t;

    // reset values of the limits
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

endpackage

### rtl/pid_step_with_windup_clamp.sv
`timescale 1ns / 1ps

// an input beat passes through the error, the integral update, the restoring divider and the
// three multiply-accumulate terms to a valid result; a zero elapsed_ms skips the divider
// throughput: one item at a time, set by the one-bit-per-cycle restoring divider and the
// 32x17 multiplier taken once per 16-bit chunk
// a finished result waits in the output register while the next beat is accepted
// reset: synchronous active-low aresetn clears gains, integral and last error, limits to max
module pid_step_with_windup_clamp
    import pidwc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [IN_W-1:0]       s_target,
    input  logic [IN_W-1:0]       s_measured,
    input  logic [DT_W-1:0]       s_elapsed_ms,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IN_W-1:0]       m_drive,
    output logic                  m_saturated
);

    localparam int W     = VALUE_WIDTH;
    localparam int XW    = ((W > IN_W) ? W : IN_W) + 2;
    localparam int NW    = W + 1;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int NCH   = (W + CHUNK_W - 1) / CHUNK_W;
    localparam int MV_W  = NCH * CHUNK_W;
    localparam int PW    = GAIN_W + MV_W;
    localparam int PRODW = GAIN_W + CHUNK_W;

    localparam logic signed [W-1:0]     VMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]     VMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] VMAX_S = SUM_W'(VMAX_W);
    localparam logic signed [SUM_W-1:0] VMIN_S = SUM_W'(VMIN_W);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ERR, ST_INTA, ST_INTB, ST_DIV, ST_DSGN, ST_LOAD, ST_MUL, ST_TERM, ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        TERM_P, TERM_I, TERM_D
    } term_t;

    // saturate a wide signed value to the datapath range
    function automatic logic signed [W-1:0] sat_w(input logic signed [SUM_W-1:0] x);
        if (x > VMAX_S) begin
            return VMAX_W;
        end else if (x < VMIN_S) begin
            return VMIN_W;
        end
        return $signed(x[W-1:0]);
    endfunction

    state_t                    state_reg;
    term_t                     term_reg;
    logic                      m_valid_reg;

    logic signed [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0]        esl_reg, il_reg;

    logic signed [IN_W-1:0]    tgt_reg, meas_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [W-1:0]       err_reg, last_err_reg, integ_reg, deriv_reg;
    logic signed [XW-1:0]      itmp_reg;
    logic                      neg_reg;
    logic [DT_W-1:0]           rem_reg;
    logic [NW-1:0]             quo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [MV_W-1:0]           mv_reg;
    logic                      first_reg;
    logic signed [PW-1:0]      acc_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [IN_W-1:0]           drive_reg;
    logic                      sat_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            esl_reg    <= LIMIT_RESET;
            il_reg     <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:           gain_p_reg <= $signed(cfg_data);
                REG_GAIN_I:           gain_i_reg <= $signed(cfg_data);
                REG_GAIN_D:           gain_d_reg <= $signed(cfg_data);
                REG_ERROR_STEP_LIMIT: esl_reg    <= cfg_data[LIMIT_W-1:0];
                REG_INTEGRAL_LIMIT:   il_reg     <= cfg_data[LIMIT_W-1:0];
                default:              ;
            endcase
        end
    end

    // error, saturated to the datapath range
    logic signed [XW-1:0] diff_x;
    logic signed [W-1:0]  err_next;
    assign diff_x   = XW'(tgt_reg) - XW'(meas_reg);
    assign err_next = sat_w(SUM_W'(diff_x));

    // integral add with per-step limit, error change for the divider
    logic signed [XW-1:0] err_x, esl_x, err_lim_x, itmp_next, dd_x, mag_x;
    assign err_x     = XW'(err_reg);
    assign esl_x     = $signed(XW'(esl_reg));
    assign err_lim_x = (err_x > esl_x) ? esl_x : ((err_x < -esl_x) ? -esl_x : err_x);
    assign itmp_next = XW'(integ_reg) + err_lim_x;
    assign dd_x      = err_x - XW'(last_err_reg);
    assign mag_x     = dd_x[XW-1] ? -dd_x : dd_x;

    // integral clamp and clear
    logic signed [XW-1:0] il_x, ic_x;
    logic signed [W-1:0]  integ_next;
    assign il_x       = $signed(XW'(il_reg));
    assign ic_x       = (itmp_reg > il_x) ? il_x : ((itmp_reg < -il_x) ? -il_x : itmp_reg);
    assign integ_next = (gain_i_reg == '0) ? '0 : sat_w(SUM_W'(ic_x));

    // restoring divider step, one quotient bit per cycle
    logic [DT_W:0]   shifted;
    logic [DT_W+1:0] trial;
    logic            ge;
    logic [DT_W-1:0] rem_next;
    logic [NW-1:0]   quo_next;
    assign shifted  = {rem_reg, quo_reg[NW-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dt_reg};
    assign ge       = !trial[DT_W+1];
    assign rem_next = ge ? trial[DT_W-1:0] : shifted[DT_W-1:0];
    assign quo_next = {quo_reg[NW-2:0], ge};

    // signed quotient, rounded toward zero
    logic signed [SUM_W-1:0] q_s;
    logic signed [W-1:0]     deriv_next;
    assign q_s        = $signed(SUM_W'(quo_reg));
    assign deriv_next = sat_w(neg_reg ? -q_s : q_s);

    // operand select for the shared multiplier
    logic signed [GAIN_W-1:0] gain_sel;
    logic signed [W-1:0]      op_sel;
    always_comb begin
        unique case (term_reg)
            TERM_P: begin
                gain_sel = gain_p_reg;
                op_sel   = err_reg;
            end
            TERM_I: begin
                gain_sel = gain_i_reg;
                op_sel   = integ_reg;
            end
            TERM_D: begin
                gain_sel = gain_d_reg;
                op_sel   = deriv_reg;
            end
            default: begin
                gain_sel = '0;
                op_sel   = '0;
            end
        endcase
    end

    // shared 32x17 multiplier, top chunk signed, lower chunks unsigned
    logic [CHUNK_W-1:0]         chunk;
    logic signed [CHUNK_W:0]    mul_b;
    logic signed [PRODW:0]      mul_full;
    logic signed [PRODW-1:0]    prod;
    logic signed [PW-1:0]       acc_next;
    assign chunk    = mv_reg[MV_W-1 -: CHUNK_W];
    assign mul_b    = $signed({first_reg ? chunk[CHUNK_W-1] : 1'b0, chunk});
    assign mul_full = gain_sel * mul_b;
    assign prod     = $signed(mul_full[PRODW-1:0]);
    assign acc_next = $signed({acc_reg[PW-CHUNK_W-1:0], {CHUNK_W{1'b0}}}) + PW'(prod);

    // floor shift, term clamp and accumulate
    logic signed [PW-FRAC_W-1:0] term_x;
    logic signed [CLAMP_W-1:0]   tx, tc;
    logic signed [SUM_W-1:0]     sum_next;
    assign term_x   = $signed(acc_reg[PW-1:FRAC_W]);
    assign tx       = CLAMP_W'(term_x);
    assign tc       = (tx > TERM_LIM) ? TERM_LIM : ((tx < -TERM_LIM) ? -TERM_LIM : tx);
    assign sum_next = sum_reg + $signed(tc[SUM_W-1:0]);

    // output saturation
    logic signed [W-1:0]     drive_w;
    logic signed [SUM_W-1:0] drive_ext;
    logic                    sat_next;
    assign drive_w   = sat_w(sum_reg);
    assign drive_ext = SUM_W'(drive_w);
    assign sat_next  = (sum_reg > VMAX_S) || (sum_reg < VMIN_S);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            term_reg     <= TERM_P;
            m_valid_reg  <= 1'b0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            // result beat taken, unless a new one is loaded in the same cycle
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        tgt_reg   <= $signed(s_target);
                        meas_reg  <= $signed(s_measured);
                        dt_reg    <= s_elapsed_ms;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg   <= err_next;
                    state_reg <= ST_INTA;
                end
                ST_INTA: begin
                    itmp_reg  <= itmp_next;
                    neg_reg   <= dd_x[XW-1];
                    quo_reg   <= mag_x[NW-1:0];
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(NW);
                    state_reg <= ST_INTB;
                end
                ST_INTB: begin
                    integ_reg    <= integ_next;
                    last_err_reg <= err_reg;
                    term_reg     <= TERM_P;
                    sum_reg      <= '0;
                    if (dt_reg == '0) begin
                        deriv_reg <= '0;
                        state_reg <= ST_LOAD;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_DSGN;
                    end
                end
                ST_DSGN: begin
                    deriv_reg <= deriv_next;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    mv_reg    <= MV_W'(op_sel);
                    acc_reg   <= '0;
                    first_reg <= 1'b1;
                    cnt_reg   <= CNT_W'(NCH);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    acc_reg   <= acc_next;
                    mv_reg    <= mv_reg << CHUNK_W;
                    first_reg <= 1'b0;
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_TERM;
                    end
                end
                ST_TERM: begin
                    sum_reg <= sum_next;
                    unique case (term_reg)
                        TERM_P: begin
                            term_reg  <= TERM_I;
                            state_reg <= ST_LOAD;
                        end
                        TERM_I: begin
                            term_reg  <= TERM_D;
                            state_reg <= ST_LOAD;
                        end
                        default: begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_FIN: begin
                    // load the result register once it is free
                    if (!m_valid_reg || m_ready) begin
                        drive_reg   <= drive_ext[IN_W-1:0];
                        sat_reg     <= sat_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_drive     = drive_reg;
    assign m_saturated = sat_reg;

endmodule

### rtl/pidwc_chk.sv
`timescale 1ns / 1ps

module pidwc_chk
    import pidwc_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic [IN_W-1:0] m_drive,
    input logic            m_saturated
);

    // busy after an input beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while an item is in progress");

    // a stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive) && $stable(m_saturated))
        else $error("result beat changed while stalled");

    // a result never appears right after an input beat
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after input");

    // a new result frees the input side
    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result loaded but input side still busy");

    // a clipped drive sits at a rail
    a_sat_at_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated && (VALUE_WIDTH == IN_W)
            |-> (m_drive == 32'h7fff_ffff || m_drive == 32'h8000_0000))
        else $error("saturated flag with drive off the rails");

endmodule

bind pid_step_with_windup_clamp pidwc_chk #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pidwc_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_drive     (m_drive),
    .m_saturated (m_saturated)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import pidwc_pkg::*;

    // saturation bounds of the 32-bit datapath and of one scaled term
    localparam longint VAL_MAX    = 64'sd2147483647;
    localparam longint VAL_MIN    = -VAL_MAX - 1;
    localparam longint TERM_BOUND = 64'sh2000_0000_0000_0000;
    localparam int     HOLD_CYCLES = 600;

    typedef struct packed {
        logic [IN_W-1:0] drive;
        logic            sat;
    } pid_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_W-1:0]       s_target;
    logic [IN_W-1:0]       s_measured;
    logic [DT_W-1:0]       s_elapsed_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic [IN_W-1:0]       m_drive;
    logic                  m_saturated;

    // controller settings and state as the block should hold them
    logic signed [GAIN_W-1:0] kp_cfg, ki_cfg, kd_cfg;
    logic [LIMIT_W-1:0]       step_lim_cfg, integ_lim_cfg;
    logic signed [IN_W-1:0]   integ_acc, prev_err;

    pid_result_t pending_drive_q[$];

    int src_idle_pct;
    int rx_stall_pct;
    bit hold_req;
    int mismatch_count;
    int steps_sent;
    int beats_checked;
    int clipped_beats;
    int zero_dt_steps;

    pid_step_with_windup_clamp DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_target     (s_target),
        .s_measured   (s_measured),
        .s_elapsed_ms (s_elapsed_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive      (m_drive),
        .m_saturated  (m_saturated)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("pid_step_with_windup_clamp regression: fail");
        $finish;
    end

    function automatic longint clamp64(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // gain times value, floored back to Q16.16 and bounded
    function automatic longint scaled(logic signed [GAIN_W-1:0] g, longint v);
        longint prod;
        prod = longint'(g) * v;
        return clamp64(prod >>> FRAC_W, -TERM_BOUND, TERM_BOUND);
    endfunction

    // one controller step: updates integral and last error, returns drive
    function automatic pid_result_t pid_predict(logic signed [IN_W-1:0] tgt,
                                                logic signed [IN_W-1:0] meas,
                                                logic [DT_W-1:0] dt);
        longint err, lim, acc, der, total;
        pid_result_t r;
        err = clamp64(longint'(tgt) - longint'(meas), VAL_MIN, VAL_MAX);
        lim = longint'(step_lim_cfg);
        acc = longint'(integ_acc) + clamp64(err, -lim, lim);
        lim = longint'(integ_lim_cfg);
        acc = clamp64(clamp64(acc, -lim, lim), VAL_MIN, VAL_MAX);
        if (ki_cfg == 0) acc = 0;
        der = 0;
        // zero elapsed time gives no derivative
        if (dt != 0) der = clamp64((err - longint'(prev_err)) / longint'(dt), VAL_MIN, VAL_MAX);
        total = scaled(kp_cfg, err) + scaled(ki_cfg, acc) + scaled(kd_cfg, der);
        r.sat   = (total > VAL_MAX) || (total < VAL_MIN);
        r.drive = IN_W'(clamp64(total, VAL_MIN, VAL_MAX));
        integ_acc = IN_W'(acc);
        prev_err  = IN_W'(err);
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // result checker
    always @(posedge aclk) begin
        pid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_checked++;
            if (m_saturated) clipped_beats++;
            if (pending_drive_q.size() == 0) begin
                note_mismatch($sformatf("unexpected beat drive %h saturated %b",
                                        m_drive, m_saturated));
            end else begin
                want = pending_drive_q.pop_front();
                if (m_drive !== want.drive)
                    note_mismatch($sformatf("drive expected %h got %h", want.drive, m_drive));
                if (m_saturated !== want.sat)
                    note_mismatch($sformatf("saturated expected %b got %b",
                                            want.sat, m_saturated));
            end
        end
    end

    // receiver: random stalls plus an occasional long hold
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            1: begin src_idle_pct = 46; rx_stall_pct = 0; end
            2: begin src_idle_pct = 0; rx_stall_pct = 46; end
            3: begin src_idle_pct = 8; rx_stall_pct = 8; end
            default: begin src_idle_pct = 0; rx_stall_pct = 0; end
        endcase
    endtask

    // register write, entered and left at a falling edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_GAIN_P:           kp_cfg = data;
            REG_GAIN_I:           ki_cfg = data;
            REG_GAIN_D:           kd_cfg = data;
            REG_ERROR_STEP_LIMIT: step_lim_cfg = data[LIMIT_W-1:0];
            REG_INTEGRAL_LIMIT:   integ_lim_cfg = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_gains_limits(input logic [31:0] kp, input logic [31:0] ki,
                                    input logic [31:0] kd, input logic [31:0] step_lim,
                                    input logic [31:0] integ_lim);
        cfg_write(REG_GAIN_P, kp);
        cfg_write(REG_GAIN_I, ki);
        cfg_write(REG_GAIN_D, kd);
        cfg_write(REG_ERROR_STEP_LIMIT, step_lim);
        cfg_write(REG_INTEGRAL_LIMIT, integ_lim);
    endtask

    // one step beat; valid stays up on return so back-to-back beats have no gap
    task automatic send_step(input logic [IN_W-1:0] tgt, input logic [IN_W-1:0] meas,
                             input logic [DT_W-1:0] dt);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_target     <= tgt;
        s_measured   <= meas;
        s_elapsed_ms <= dt;
        do @(posedge aclk); while (!s_ready);
        pending_drive_q.push_back(pid_predict(tgt, meas, dt));
        steps_sent++;
        if (dt == 0) zero_dt_steps++;
        @(negedge aclk);
    endtask

    // drop valid and wait for every outstanding drive
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(negedge aclk);
    endtask

    // defaults after reset and writes to unused indexes
    task automatic test_reset_defaults();
        send_step(32'h0006_4000, 32'h0003_2000, 16'd10);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        drain();
        for (int i = REG_INTEGRAL_LIMIT + 1; i < (1 << CFG_IDX_W); i++)
            cfg_write(CFG_IDX_W'(i), '1);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        drain();
    endtask

    // error extremes, elapsed time edges and the integral clamps
    task automatic test_error_extremes();
        set_gains_limits(32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                         32'h0003_0000, 32'h0005_0000);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        send_step(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        send_step(32'h0000_0001, 32'h0000_0000, 16'd1);
        send_step(32'hFFFF_FFFF, 32'h0000_0000, 16'd0);
        send_step(32'h8000_0000, 32'h8000_0000, 16'd3);
        drain();
    endtask

    // full-scale gains drive the output into both rails
    task automatic test_output_saturation();
        set_gains_limits(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        send_step(32'h7FFF_FFFF, 32'h0000_0000, 16'd2);
        drain();
    endtask

    // zero integral gain clears the sum; zero limits keep it at zero
    task automatic test_integral_clear();
        cfg_write(REG_GAIN_I, 32'h0000_0000);
        send_step(32'h0010_0000, 32'h0000_0000, 16'd5);
        send_step(32'h0010_0000, 32'h0000_0000, 16'd5);
        drain();
        set_gains_limits(32'h0000_8000, 32'h0001_0000, 32'h8000_0000,
                         32'h0000_0000, 32'h0000_0000);
        send_step(32'h0010_0000, 32'hFFF0_0000, 16'd4);
        send_step(32'hFFF0_0000, 32'h0010_0000, 16'd4);
        drain();
        cfg_write(REG_ERROR_STEP_LIMIT, 32'h7FFF_FFFF);
        cfg_write(REG_INTEGRAL_LIMIT, 32'h8000_0000);
        send_step(32'h0020_0000, 32'h0000_0000, 16'd7);
        drain();
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(6))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return 32'(int'($urandom_range(20 * 65536)) - 10 * 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return {1'($urandom_range(1)), 31'($urandom_range(50 * 65536))};
        endcase
    endfunction

    // mostly a measurement tracking its setpoint, some noise and rail values
    task automatic send_random_step();
        logic [IN_W-1:0] tgt, meas, off;
        logic [DT_W-1:0] dt;
        case ($urandom_range(9))
            0: begin
                tgt  = $urandom;
                meas = $urandom;
            end
            1: begin
                tgt  = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                meas = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            default: begin
                tgt = $urandom;
                off = $urandom_range(1 << 20);
                if ($urandom_range(1)) off = -off;
                meas = tgt - off;
            end
        endcase
        case ($urandom_range(19))
            0, 1:          dt = '0;
            2:             dt = '1;
            3, 4, 5, 6, 7: dt = DT_W'($urandom);
            default:       dt = DT_W'($urandom_range(50, 1));
        endcase
        send_step(tgt, meas, dt);
    endtask

    // random settings over each idling mode
    task automatic test_random_sweep();
        for (int ph = 0; ph < 8; ph++) begin
            set_idle(ph % 4);
            set_gains_limits(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
            for (int n = 0; n < 228; n++) send_random_step();
            drain();
        end
    endtask

    // long output hold while beats keep coming, so the input stalls
    task automatic test_output_hold();
        set_idle(0);
        set_gains_limits(32'h0001_8000, 32'h0000_4000, 32'hFFFF_0000,
                         32'h0008_0000, 32'h0040_0000);
        @(posedge aclk);
        hold_req = 1'b1;
        @(negedge aclk);
        for (int n = 0; n < 12; n++) send_random_step();
        drain();
    endtask

    initial begin : stimulus
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_target      = '0;
        s_measured    = '0;
        s_elapsed_ms  = '0;
        hold_req      = 1'b0;
        kp_cfg        = '0;
        ki_cfg        = '0;
        kd_cfg        = '0;
        step_lim_cfg  = LIMIT_RESET;
        integ_lim_cfg = LIMIT_RESET;
        integ_acc     = '0;
        prev_err      = '0;
        set_idle(0);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_error_extremes();
        test_output_saturation();
        test_integral_clear();
        test_output_hold();
        test_random_sweep();

        drain();
        repeat (60) @(negedge aclk);
        $display("checked %0d drive beats from %0d steps; %0d clipped, %0d with zero elapsed time",
                 beats_checked, steps_sent, clipped_beats, zero_dt_steps);
        $display("settings: reset defaults, unused indexes, rail gains and limits, "
                 , "8 random phases over four idling modes, one long output hold");
        if (mismatch_count == 0 && pending_drive_q.size() == 0) begin
            $display("pid_step_with_windup_clamp regression: pass");
        end else begin
            $display("pid_step_with_windup_clamp regression: fail");
        end
        $finish;
    end

endmodule
